### hw/rtl/dtle_pkg.sv
// Shared types and constants for the DRAT text line encoder.
`timescale 1ns / 1ps

package dtle_pkg;

	localparam logic [1:0] CMD_BEGIN   = 2'd0;
	localparam logic [1:0] CMD_LITERAL = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;

	localparam logic [2:0] KIND_DELETED   = 3'd0;
	localparam logic [2:0] KIND_INPUT     = 3'd1;
	localparam logic [2:0] KIND_REDUNDANT = 3'd2;
	localparam logic [2:0] KIND_ASSERTED  = 3'd3;

	localparam logic [7:0] CHAR_D       = 8'h64;
	localparam logic [7:0] CHAR_I       = 8'h69;
	localparam logic [7:0] CHAR_R       = 8'h72;
	localparam logic [7:0] CHAR_A       = 8'h61;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

	localparam logic [0:0] REG_EXTENSION_PRESENT = 1'b0;

	typedef struct packed {
		logic load;
		logic step;
		logic shift_digit;
	} bcd_ctrl_t;

endpackage

### hw/rtl/dtle_item_if.sv
// Input item channel: clause commands and literals.
`timescale 1ns / 1ps

interface dtle_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [2:0]  kind;
	logic [31:0] variable;
	logic        negated;

	modport source (output valid, command, kind, variable, negated, input ready);
	modport sink (input valid, command, kind, variable, negated, output ready);
endinterface

### hw/rtl/dtle_byte_if.sv
// Output channel: one text byte per beat.
`timescale 1ns / 1ps

interface dtle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, text_byte, last_byte, input ready);
	modport sink (input valid, text_byte, last_byte, output ready);
endinterface

### hw/rtl/dtle_apb_regs.sv
// APB configuration register block for the DRAT text line encoder.
`timescale 1ns / 1ps

module dtle_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        extension_present
);

	logic ext_q;
	logic wr_en;
	logic hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == dtle_pkg::REG_EXTENSION_PRESENT);
	assign wr_en  = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
		end else if (wr_en) begin
			ext_q <= pwdata[0];
		end
	end

	assign prdata            = hit ? {31'd0, ext_q} : 32'd0;
	assign extension_present = ext_q;

endmodule

### hw/rtl/dtle_bcd_unit.sv
// Shared shift and add-3 unit: binary to BCD, then digit shift-out from the top.
`timescale 1ns / 1ps

module dtle_bcd_unit #(
	parameter int VAR_BITS = 32,
	parameter int NDIG     = 10
) (
	input  logic                  clk,
	input  dtle_pkg::bcd_ctrl_t   ctrl,
	input  logic [VAR_BITS-1:0]   load_value,
	output logic [3:0]            top_digit
);

	localparam int BW = 4 * NDIG;

	logic [VAR_BITS-1:0] bin_q;
	logic [BW-1:0]       bcd_q;
	logic [BW-1:0]       bcd_adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= load_value;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[VAR_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BW-2:0], bin_q[VAR_BITS-1]};
		end else if (ctrl.shift_digit) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BW-1 -: 4];

endmodule

### hw/rtl/drat_text_line_encoder.sv
// Top level: DRAT proof text line encoder with its clause sequencer.
// Begin with prefix: emits the kind letter and a space, 2 bytes, then returns to idle.
// Literal: shift/add-3 conversion, then an optional minus sign, zero skip, digit bytes and a
// space; a zero variable gives no digits. The next item is accepted only once the sequencer is idle.
// End: 2 bytes, zero and newline; other items emit nothing. Output stalls hold the emitting states.
// Reset clears the sequencer, the output valid flag, the suppression flag and the register.
`timescale 1ns / 1ps

module drat_text_line_encoder #(
	parameter int VAR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dtle_item_if.sink   items,
	dtle_byte_if.source text,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NDIG = (VAR_BITS * 77) / 256 + 1;
	localparam int CW   = $clog2(VAR_BITS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_LEAD  = 9'b000000010,
		ST_SPACE = 9'b000000100,
		ST_CONV  = 9'b000001000,
		ST_SIGN  = 9'b000010000,
		ST_SKIP  = 9'b000100000,
		ST_DIGIT = 9'b001000000,
		ST_ZERO  = 9'b010000000,
		ST_NL    = 9'b100000000
	} state_t;

	state_t              state_q;
	logic                supp_q;
	logic                neg_q;
	logic                zero_q;
	logic [7:0]          lead_q;
	logic [CW-1:0]       cnt_q;
	logic                text_valid_q;
	logic [7:0]          text_byte_q;
	logic                last_byte_q;

	logic                ext;
	logic                accept;
	logic                can_load;
	logic                emit;
	logic                fire;
	logic [7:0]          emit_byte;
	logic                emit_last;
	logic [7:0]          lead_char;
	logic [VAR_BITS-1:0] var_masked;
	logic [3:0]          top_digit;
	dtle_pkg::bcd_ctrl_t bcd_ctrl;

	dtle_apb_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.extension_present (ext)
	);

	dtle_bcd_unit #(
		.VAR_BITS (VAR_BITS),
		.NDIG     (NDIG)
	) u_bcd (
		.clk        (clk),
		.ctrl       (bcd_ctrl),
		.load_value (var_masked),
		.top_digit  (top_digit)
	);

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign var_masked  = items.variable[VAR_BITS-1:0];
	assign can_load    = !text_valid_q || text.ready;
	assign fire        = emit && can_load;

	always_comb begin
		case (items.kind)
			dtle_pkg::KIND_DELETED:   lead_char = dtle_pkg::CHAR_D;
			dtle_pkg::KIND_INPUT:     lead_char = dtle_pkg::CHAR_I;
			dtle_pkg::KIND_REDUNDANT: lead_char = dtle_pkg::CHAR_R;
			dtle_pkg::KIND_ASSERTED:  lead_char = dtle_pkg::CHAR_A;
			default:                  lead_char = 8'd0;
		endcase
	end

	always_comb begin
		emit      = 1'b1;
		emit_byte = dtle_pkg::CHAR_SPACE;
		emit_last = 1'b0;
		case (state_q)
			ST_LEAD:  emit_byte = lead_q;
			ST_SPACE: emit_last = 1'b1;
			ST_SIGN:  emit_byte = dtle_pkg::CHAR_MINUS;
			ST_DIGIT: emit_byte = dtle_pkg::CHAR_ZERO + {4'd0, top_digit};
			ST_ZERO:  emit_byte = dtle_pkg::CHAR_ZERO;
			ST_NL: begin
				emit_byte = dtle_pkg::CHAR_NEWLINE;
				emit_last = 1'b1;
			end
			default:  emit = 1'b0;
		endcase
	end

	assign bcd_ctrl.load        = accept && (items.command == dtle_pkg::CMD_LITERAL) && !supp_q;
	assign bcd_ctrl.step        = (state_q == ST_CONV);
	assign bcd_ctrl.shift_digit = ((state_q == ST_SKIP) && (top_digit == 4'd0))
		|| ((state_q == ST_DIGIT) && fire);

	always_ff @(posedge clk) begin
		if (fire) begin
			text_byte_q <= emit_byte;
			last_byte_q <= emit_last;
		end
		if (accept) begin
			neg_q  <= items.negated;
			zero_q <= (var_masked == '0);
			lead_q <= lead_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			supp_q       <= 1'b0;
			text_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (fire) begin
				text_valid_q <= 1'b1;
			end else if (text.ready) begin
				text_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (items.command)
							dtle_pkg::CMD_BEGIN: begin
								if (items.kind == dtle_pkg::KIND_ASSERTED && !ext) begin
									supp_q <= 1'b1;
								end else begin
									supp_q <= 1'b0;
									if (items.kind inside {[dtle_pkg::KIND_DELETED:
										dtle_pkg::KIND_ASSERTED]}) begin
										state_q <= ST_LEAD;
									end
								end
							end
							dtle_pkg::CMD_LITERAL: begin
								if (!supp_q) begin
									cnt_q   <= CW'(VAR_BITS - 1);
									state_q <= ST_CONV;
								end
							end
							dtle_pkg::CMD_END: begin
								if (supp_q) begin
									supp_q <= 1'b0;
								end else begin
									state_q <= ST_ZERO;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						cnt_q <= CW'(NDIG - 1);
						if (neg_q) begin
							state_q <= ST_SIGN;
						end else if (zero_q) begin
							state_q <= ST_SPACE;
						end else begin
							state_q <= ST_SKIP;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SIGN: begin
					if (fire) begin
						state_q <= zero_q ? ST_SPACE : ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit != 4'd0) begin
						state_q <= ST_DIGIT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIGIT: begin
					if (fire) begin
						if (cnt_q == '0) begin
							state_q <= ST_SPACE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				ST_LEAD: begin
					if (fire) begin
						state_q <= ST_SPACE;
					end
				end
				ST_SPACE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ZERO: begin
					if (fire) begin
						state_q <= ST_NL;
					end
				end
				ST_NL: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign text.valid     = text_valid_q;
	assign text.text_byte = text_byte_q;
	assign text.last_byte = last_byte_q;

endmodule

### tb/sv/tb_drat_text_line_encoder.sv
// Self-checking testbench for the DRAT text line encoder: predicts each text byte and compares.
`timescale 1ns / 1ps

module tb_drat_text_line_encoder;

	localparam int VAR_BITS = 32;
	localparam logic [63:0] VAR_MASK = (64'd1 << VAR_BITS) - 64'd1;
	localparam logic [2:0] KIND_PLAIN = 3'd4;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [2:0] ADDR_EXTENSION = {dtle_pkg::REG_EXTENSION_PRESENT, 2'b00};
	localparam int SETTLE_CYCLES = 4 * VAR_BITS + 16;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]  command;
		logic [2:0]  kind;
		logic [31:0] variable;
		logic        negated;
	} clause_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dtle_item_if items_if ();
	dtle_byte_if text_if ();

	drat_text_line_encoder #(
		.VAR_BITS(VAR_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.text(text_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	clause_item_t pending_items[$];
	text_beat_t   expected_text[$];
	clause_item_t next_item;

	logic ext_present;
	logic clause_dropped;
	logic stall_hold;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   mismatches;
	int   items_taken;
	int   bytes_checked;
	int   clauses_dropped;
	int   config_writes;
	event stall_request;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic void predict_line(input clause_item_t it);
		logic [7:0] line[$];
		logic [7:0] digit[10];
		logic [7:0] lead;
		logic [31:0] v;
		text_beat_t beat;
		int nd;
		lead = 8'h00;
		nd = 0;
		case (it.command)
			dtle_pkg::CMD_BEGIN: begin
				if (it.kind == dtle_pkg::KIND_ASSERTED && !ext_present) begin
					clause_dropped = 1'b1;
					clauses_dropped++;
				end else begin
					clause_dropped = 1'b0;
					case (it.kind)
						dtle_pkg::KIND_DELETED:   lead = dtle_pkg::CHAR_D;
						dtle_pkg::KIND_INPUT:     lead = dtle_pkg::CHAR_I;
						dtle_pkg::KIND_REDUNDANT: lead = dtle_pkg::CHAR_R;
						dtle_pkg::KIND_ASSERTED:  lead = dtle_pkg::CHAR_A;
						default:                  lead = 8'h00;
					endcase
					if (lead != 8'h00) begin
						line.insert(line.size(), lead);
						line.insert(line.size(), dtle_pkg::CHAR_SPACE);
					end
				end
			end
			dtle_pkg::CMD_LITERAL: begin
				if (!clause_dropped) begin
					if (it.negated)
						line.insert(line.size(), dtle_pkg::CHAR_MINUS);
					v = it.variable & VAR_MASK[31:0];
					while (v > 0 && nd < 10) begin
						digit[nd] = dtle_pkg::CHAR_ZERO + 8'(v % 10);
						v = v / 10;
						nd++;
					end
					for (int i = nd - 1; i >= 0; i--)
						line.insert(line.size(), digit[i]);
					line.insert(line.size(), dtle_pkg::CHAR_SPACE);
				end
			end
			dtle_pkg::CMD_END: begin
				if (clause_dropped) begin
					clause_dropped = 1'b0;
				end else begin
					line.insert(line.size(), dtle_pkg::CHAR_ZERO);
					line.insert(line.size(), dtle_pkg::CHAR_NEWLINE);
				end
			end
			default: ;
		endcase
		foreach (line[i]) begin
			beat.ch = line[i];
			beat.last = (i == line.size() - 1);
			expected_text.insert(expected_text.size(), beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			items_if.command <= '0;
			items_if.kind <= '0;
			items_if.variable <= '0;
			items_if.negated <= 1'b0;
		end else if (!items_if.valid || items_if.ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				items_if.valid <= 1'b1;
				items_if.command <= next_item.command;
				items_if.kind <= next_item.kind;
				items_if.variable <= next_item.variable;
				items_if.negated <= next_item.negated;
			end else begin
				items_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			text_if.ready <= 1'b0;
		else
			text_if.ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	always begin
		@(stall_request);
		@(negedge clk);
		stall_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		stall_hold = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (items_if.valid && items_if.ready) begin
				predict_line('{command: items_if.command, kind: items_if.kind,
					variable: items_if.variable, negated: items_if.negated});
				items_taken++;
			end
			if (text_if.valid && text_if.ready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected byte 8'h%02h", text_if.text_byte));
				end else begin
					if (text_if.text_byte !== expected_text[0].ch)
						report_mismatch($sformatf("text_byte 8'h%02h, want 8'h%02h",
							text_if.text_byte, expected_text[0].ch));
					if (text_if.last_byte !== expected_text[0].last)
						report_mismatch($sformatf("last_byte %0b, want %0b on 8'h%02h",
							text_if.last_byte, expected_text[0].last, expected_text[0].ch));
					void'(expected_text.pop_front());
				end
				bytes_checked++;
			end
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_EXTENSION)
			ext_present = data[0];
		config_writes++;
	endtask

	task automatic push_item(input logic [1:0] cmd, input logic [2:0] kind,
			input logic [31:0] variable, input logic negated);
		clause_item_t it;
		it.command = cmd;
		it.kind = kind;
		it.variable = variable;
		it.negated = negated;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic logic [31:0] pick_variable();
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(5))
			0: return 32'd0;
			1: return $urandom_range(99, 1);
			2: return $urandom;
			3: begin
				repeat ($urandom_range(9, 1)) p = p * 10;
				return p - $urandom_range(1);
			end
			4: return 32'hFFFF_FFFF;
			default: return $urandom_range(99999, 1000);
		endcase
	endfunction

	task automatic add_random_items(input int count);
		int made;
		int nlit;
		logic [2:0] k;
		logic [1:0] cmd;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 75) begin
				k = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
				push_item(dtle_pkg::CMD_BEGIN, k, $urandom, 1'($urandom_range(1)));
				nlit = $urandom_range(4);
				repeat (nlit)
					push_item(dtle_pkg::CMD_LITERAL, 3'($urandom_range(7)), pick_variable(),
						1'($urandom_range(1)));
				push_item(dtle_pkg::CMD_END, 3'($urandom_range(7)), $urandom,
					1'($urandom_range(1)));
				made += nlit + 2;
			end else begin
				cmd = 2'($urandom_range(3));
				push_item(cmd, 3'($urandom_range(7)), pick_variable(), 1'($urandom_range(1)));
				if (cmd != CMD_NONE)
					made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || items_if.valid || expected_text.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_if.valid = 1'b0;
		items_if.command = '0;
		items_if.kind = '0;
		items_if.variable = '0;
		items_if.negated = 1'b0;
		text_if.ready = 1'b0;
		stall_hold = 1'b0;
		ext_present = 1'b0;
		clause_dropped = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 80;
		mismatches = 0;
		items_taken = 0;
		bytes_checked = 0;
		clauses_dropped = 0;
		config_writes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(ADDR_EXTENSION, 32'd0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd7, 1'b0);
		push_item(dtle_pkg::CMD_END, 3'd7, 32'hFFFF_FFFF, 1'b1);
		push_item(CMD_NONE, 3'd7, 32'hFFFF_FFFF, 1'b1);
		push_item(dtle_pkg::CMD_BEGIN, dtle_pkg::KIND_DELETED, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd0, 1'b1);
		push_item(dtle_pkg::CMD_LITERAL, 3'd7, 32'hFFFF_FFFF, 1'b1);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_BEGIN, dtle_pkg::KIND_INPUT, 32'hFFFF_FFFF, 1'b1);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd1_000_000_000, 1'b0);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_BEGIN, dtle_pkg::KIND_REDUNDANT, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd9, 1'b1);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_BEGIN, dtle_pkg::KIND_ASSERTED, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd10, 1'b0);
		push_item(CMD_NONE, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_BEGIN, KIND_PLAIN, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_BEGIN, 3'd7, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd99, 1'b0);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		add_random_items(20);
		wait_drained();

		send_idle_pct = 80;
		recv_idle_pct = 33;
		write_reg(ADDR_EXTENSION, 32'hFFFF_FFFF);
		push_item(dtle_pkg::CMD_BEGIN, dtle_pkg::KIND_ASSERTED, 32'd0, 1'b0);
		push_item(dtle_pkg::CMD_LITERAL, 3'd0, 32'd123, 1'b1);
		push_item(dtle_pkg::CMD_END, 3'd0, 32'd0, 1'b0);
		add_random_items(20);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(ADDR_EXTENSION, 32'd0);
		-> stall_request;
		add_random_items(20);
		wait_drained();

		write_reg(ADDR_EXTENSION, 32'd1);
		add_random_items(20);
		wait_drained();

		$display("Run covered %0d clause items (%0d asserted clauses dropped), %0d bytes checked.",
			items_taken, clauses_dropped, bytes_checked);
		$display("Extension register written %0d times across four phases, one long stall.",
			config_writes);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
